// File: src/qfpd_pkg.sv
package qfpd_pkg;

  // Build-time defaults
  localparam int unsigned KeyMaxDefault  = 8;
  localparam logic [15:0] DefaultLimit   = 16'd1024;
  localparam logic [63:0] KeyTextReset   = 64'd6775156;
  localparam logic [3:0]  KeyLengthReset = 4'd3;

  // Result burst per input word
  localparam int unsigned MaxResults = 4;
  localparam int unsigned ResCntW    = 3;
  localparam int unsigned ResIdxW    = 2;

  // Configuration port
  localparam int unsigned CfgAddrW       = 5;
  localparam logic [1:0]  REG_KEY_TEXT   = 2'd0;
  localparam logic [1:0]  REG_KEY_LENGTH = 2'd1;
  localparam logic [1:0]  REG_MAX_LENGTH = 2'd2;

  // Characters
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNul   = 8'h00;

  // Scan phases
  localparam logic [2:0] PH_SEARCH     = 3'd0;
  localparam logic [2:0] PH_SKIP       = 3'd1;
  localparam logic [2:0] PH_FIRST      = 3'd2;
  localparam logic [2:0] PH_DECODE     = 3'd3;
  localparam logic [2:0] PH_DONE_FOUND = 3'd4;
  localparam logic [2:0] PH_DONE_MISS  = 3'd5;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [63:0] key_text;
    logic [3:0]  key_length;
    logic [15:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic       found;
    logic       kind;
    logic [7:0] out_byte;
  } res_t;

  function automatic logic [7:0] lower_of(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    else v = 8'h00;
    return v[3:0];
  endfunction

endpackage

// File: src/qfpd_scan.sv
module qfpd_scan #(
  parameter int unsigned KEY_MAX_CHARS = qfpd_pkg::KeyMaxDefault
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      step_i,
  input  logic [7:0]                                byte_i,
  input  logic                                      eos_i,
  input  qfpd_pkg::cfg_t                            cfg_i,
  output qfpd_pkg::res_t [qfpd_pkg::MaxResults-1:0] res_o,
  output logic [qfpd_pkg::ResCntW-1:0]              res_n_o
);
  import qfpd_pkg::*;

  localparam int unsigned WinW  = 8 * KEY_MAX_CHARS;
  localparam int unsigned FillW = $clog2(KEY_MAX_CHARS + 1);

  logic [WinW-1:0]  win_q, win_d;
  logic [2:0]       phase_q, phase_d;
  logic [7:0]       hb_q, hb_d;
  logic [1:0]       hc_q, hc_d;
  logic [15:0]      ec_q, ec_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [3:0]       len;
  logic             hit;
  logic             run_dec;
  logic             consumed;
  logic [1:0]       flush_n;
  logic             fnd;
  logic [ResCntW-1:0]              n;
  res_t [MaxResults-1:0]           r;

  // Emit one decoded byte if the value is still open and the limit allows
  function automatic void put_byte(input logic [7:0] b, input logic [15:0] lim,
                                   inout logic [2:0] ph, inout logic [15:0] ec,
                                   inout logic [ResCntW-1:0] cnt,
                                   inout res_t [MaxResults-1:0] rb);
    if (ph == PH_DECODE) begin
      if (ec < lim) begin
        if (cnt < ResCntW'(MaxResults)) begin
          rb[cnt[ResIdxW-1:0]] = '{found: 1'b0, kind: KIND_DATA, out_byte: b};
          cnt = cnt + 1'b1;
        end
        ec = ec + 16'd1;
      end else begin
        ph = PH_DONE_FOUND;
      end
    end
  endfunction

  assign len = (cfg_i.key_length > 4'(KEY_MAX_CHARS)) ? 4'(KEY_MAX_CHARS) : cfg_i.key_length;

  always_comb begin
    win_d    = win_q;
    phase_d  = phase_q;
    hb_d     = hb_q;
    hc_d     = hc_q;
    ec_d     = ec_q;
    fill_d   = fill_q;
    n        = '0;
    r        = '0;
    hit      = 1'b1;
    run_dec  = 1'b0;
    consumed = 1'b0;
    flush_n  = '0;
    fnd      = 1'b0;

    if (phase_d == PH_SEARCH && len == 4'd0) phase_d = PH_SKIP;

    unique case (phase_d)
      PH_SEARCH: begin
        if (byte_i == ChNul) begin
          phase_d = PH_DONE_MISS;
        end else begin
          win_d = win_d >> 8;
          win_d[WinW-1 -: 8] = lower_of(byte_i);
          if (fill_d < FillW'(KEY_MAX_CHARS)) fill_d = fill_d + 1'b1;
          // compare the newest len bytes of the window against the key
          for (int i = 0; i < KEY_MAX_CHARS; i++) begin
            if (4'(i) < len) begin
              if (win_d[8*(i + KEY_MAX_CHARS - int'(len)) +: 8] !=
                  lower_of(cfg_i.key_text[8*i +: 8])) hit = 1'b0;
            end
          end
          if (4'(fill_d) >= len && hit) phase_d = PH_SKIP;
        end
      end
      PH_SKIP: phase_d = (byte_i != ChNul) ? PH_FIRST : PH_DONE_MISS;
      PH_FIRST: begin
        if (byte_i == ChNul) begin
          phase_d = PH_DONE_MISS;
        end else begin
          phase_d = PH_DECODE;
          run_dec = 1'b1;
        end
      end
      PH_DECODE: run_dec = 1'b1;
      default: ;
    endcase

    if (run_dec) begin
      if (hc_d == 2'd2) begin
        if (is_hex(byte_i)) begin
          hc_d     = 2'd0;
          consumed = 1'b1;
          put_byte({hex_val(hb_d), hex_val(byte_i)}, cfg_i.max_length, phase_d, ec_d, n, r);
          hb_d     = 8'h00;
        end else begin
          hc_d = 2'd0;
          put_byte(ChPct, cfg_i.max_length, phase_d, ec_d, n, r);
          put_byte(hb_d, cfg_i.max_length, phase_d, ec_d, n, r);
          hb_d = 8'h00;
        end
      end else if (hc_d == 2'd1) begin
        if (is_hex(byte_i)) begin
          hb_d     = byte_i;
          hc_d     = 2'd2;
          consumed = 1'b1;
        end else begin
          hc_d = 2'd0;
          put_byte(ChPct, cfg_i.max_length, phase_d, ec_d, n, r);
          hb_d = 8'h00;
        end
      end

      if (!consumed) begin
        if (byte_i == ChNul) begin
          if (phase_d == PH_DECODE) phase_d = PH_DONE_FOUND;
        end else if (phase_d == PH_DECODE) begin
          if (ec_d >= cfg_i.max_length || byte_i == ChAmp) begin
            phase_d = PH_DONE_FOUND;
          end else if (byte_i == ChCr || byte_i == ChLf || byte_i == ChTab) begin
            // drop line breaks and tabs
          end else if (byte_i == ChPlus) begin
            put_byte(ChSpace, cfg_i.max_length, phase_d, ec_d, n, r);
          end else if (byte_i == ChPct) begin
            hc_d = 2'd1;
          end else begin
            put_byte(byte_i, cfg_i.max_length, phase_d, ec_d, n, r);
          end
        end
      end
    end

    if (eos_i) begin
      // release a pending escape literally, then report
      if (phase_d == PH_DECODE) begin
        flush_n = hc_d;
        hc_d    = 2'd0;
        if (flush_n >= 2'd1) put_byte(ChPct, cfg_i.max_length, phase_d, ec_d, n, r);
        if (flush_n >= 2'd2) put_byte(hb_d, cfg_i.max_length, phase_d, ec_d, n, r);
        hb_d = 8'h00;
      end
      fnd = (phase_d == PH_DECODE) || (phase_d == PH_DONE_FOUND);
      if (n < ResCntW'(MaxResults)) begin
        r[n[ResIdxW-1:0]] = '{found: fnd, kind: KIND_STATUS, out_byte: 8'h00};
        n = n + 1'b1;
      end
      win_d   = '0;
      phase_d = PH_SEARCH;
      hb_d    = 8'h00;
      hc_d    = 2'd0;
      ec_d    = 16'd0;
      fill_d  = '0;
    end
  end

  assign res_o   = r;
  assign res_n_o = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      phase_q <= PH_SEARCH;
      hb_q    <= 8'h00;
      hc_q    <= 2'd0;
      ec_q    <= 16'd0;
      fill_q  <= '0;
    end else if (step_i) begin
      win_q   <= win_d;
      phase_q <= phase_d;
      hb_q    <= hb_d;
      hc_q    <= hc_d;
      ec_q    <= ec_d;
      fill_q  <= fill_d;
    end
  end

endmodule

// File: src/qfpd_obuf.sv
module qfpd_obuf (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      load_i,
  input  qfpd_pkg::res_t [qfpd_pkg::MaxResults-1:0] res_i,
  input  logic [qfpd_pkg::ResCntW-1:0]              res_n_i,
  output logic                                      free_o,
  output logic                                      valid_o,
  input  logic                                      ready_i,
  output qfpd_pkg::res_t                            res_o,
  output logic                                      last_o
);
  import qfpd_pkg::*;

  res_t [MaxResults-1:0] entries_q;
  logic [ResCntW-1:0]    cnt_q;
  logic [ResIdxW-1:0]    idx_q;
  logic                  pop;

  assign valid_o = (cnt_q != '0);
  assign last_o  = (ResCntW'(idx_q) == cnt_q - 1'b1);
  assign res_o   = entries_q[idx_q];
  assign pop     = valid_o && ready_i;
  // take a new burst when empty or once the final word of the current one leaves
  assign free_o  = !valid_o || (pop && last_o);

  always_ff @(posedge clk_i) begin
    if (load_i) entries_q <= res_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= res_n_i;
      idx_q <= '0;
    end else if (pop) begin
      if (last_o) begin
        cnt_q <= '0;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

endmodule

// File: src/query_field_percent_decoder_core.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/tready         tdata in_byte, tlast end_of_string
// m_axis    out  m_axis_tvalid/tready         tdata out_byte, tuser {found,kind}, tlast last
// apb       in   psel/penable/pwrite, pready  key_text @0x00, key_length @0x08, max_length @0x10
//
// One input word is taken per cycle while the output keeps up; a word waits in the input
// register until the result buffer loads its burst and presents the first result. A word
// with n results holds the output for all n, one per cycle while m_axis_tready is high,
// and the scan behind it waits for the last one. Reset clears the scan state, the input
// valid flag and result count, and loads register defaults. With m_axis_tready low the result
// buffer holds and one further word waits in the input register before s_axis_tready drops.
module query_field_percent_decoder_core #(
  parameter int unsigned KEY_MAX_CHARS = qfpd_pkg::KeyMaxDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,   // [7:0] in_byte
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [7:0]                    m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0]                    m_axis_tuser_o,   // [0] kind, [1] found
  output logic                          m_axis_tlast_o,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [qfpd_pkg::CfgAddrW-1:0] paddr_i,
  input  logic [63:0]                   pwdata_i,
  output logic [63:0]                   prdata_o,
  output logic                          pready_o
);
  import qfpd_pkg::*;

  logic                  in_valid_q;
  logic [7:0]            in_byte_q;
  logic                  in_eos_q;
  logic                  step;
  logic                  obuf_free;
  cfg_t                  cfg_q;
  res_t [MaxResults-1:0] res;
  logic [ResCntW-1:0]    res_n;
  res_t                  m_res;
  logic                  cfg_wr;

  // Configuration registers
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_text   <= KeyTextReset;
      cfg_q.key_length <= KeyLengthReset;
      cfg_q.max_length <= DefaultLimit;
    end else if (cfg_wr) begin
      unique case (paddr_i[4:3])
        REG_KEY_TEXT:   cfg_q.key_text   <= pwdata_i;
        REG_KEY_LENGTH: cfg_q.key_length <= pwdata_i[3:0];
        REG_MAX_LENGTH: cfg_q.max_length <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[4:3])
      REG_KEY_TEXT:   prdata_o = cfg_q.key_text;
      REG_KEY_LENGTH: prdata_o = {60'd0, cfg_q.key_length};
      REG_MAX_LENGTH: prdata_o = {48'd0, cfg_q.max_length};
      default:        prdata_o = 64'd0;
    endcase
  end

  // Input register: hold the word until the result buffer can take its burst
  assign step            = in_valid_q && obuf_free;
  assign s_axis_tready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_eos_q  <= s_axis_tlast_i;
    end
  end

  qfpd_scan #(
    .KEY_MAX_CHARS (KEY_MAX_CHARS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .eos_i   (in_eos_q),
    .cfg_i   (cfg_q),
    .res_o   (res),
    .res_n_o (res_n)
  );

  qfpd_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .res_i   (res),
    .res_n_i (res_n),
    .free_o  (obuf_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (m_res),
    .last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = m_res.out_byte;
  assign m_axis_tuser_o = {m_res.found, m_res.kind};

  ap_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0] == KIND_STATUS) |-> m_axis_tlast_o)
    else $error("status word not last of its burst");

  ap_data_no_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0] == KIND_DATA) |-> !m_axis_tuser_o[1])
    else $error("data word carries found flag");

  ap_eos_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_eos_q) |-> (res_n != '0))
    else $error("end of string without status");

  ap_burst_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res_n != '0) |=> m_axis_tvalid_o)
    else $error("loaded burst not presented");

endmodule

// File: verif/query_field_percent_decoder_checker.sv
module query_field_percent_decoder_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  input  logic [7:0]                    s_axis_tdata_i,   // [7:0] in_byte
  input  logic                          s_axis_tlast_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  input  logic [7:0]                    m_axis_tdata_i,   // [7:0] out_byte
  input  logic [1:0]                    m_axis_tuser_i,   // [0] kind, [1] found
  input  logic                          m_axis_tlast_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [qfpd_pkg::CfgAddrW-1:0] paddr_i,
  input  logic [63:0]                   pwdata_i,
  input  logic                          pready_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o,
  output int                            found_o
);
  import qfpd_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       kind;
    logic       found;
    logic       last;
  } dec_word_t;

  // Register copies
  logic [63:0] key_q;
  logic [3:0]  klen_q;
  logic [15:0] limit_q;

  // Scan state of the current string
  logic [63:0] window_q;
  logic [2:0]  scan_ph;
  logic [15:0] held_q;
  logic [1:0]  held_n;
  logic [15:0] emit_n;
  logic [3:0]  fill_n;

  dec_word_t step_q[$];
  dec_word_t decoded_q[$];
  dec_word_t want;
  dec_word_t got;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
  endfunction

  function automatic logic is_hex_digit(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] t;
    if (c >= "0" && c <= "9") t = c - 8'h30;
    else if (c >= "a" && c <= "f") t = c - 8'h57;
    else if (c >= "A" && c <= "F") t = c - 8'h37;
    else t = 8'h00;
    return t[3:0];
  endfunction

  function automatic void clear_scan();
    window_q = '0;
    scan_ph  = PH_SEARCH;
    held_q   = '0;
    held_n   = '0;
    emit_n   = '0;
    fill_n   = '0;
  endfunction

  function automatic void push_word(input logic [7:0] b, input logic k, input logic f);
    dec_word_t w;
    if (step_q.size() >= MaxResults) return;
    w.out_byte = b;
    w.kind     = k;
    w.found    = f;
    w.last     = 1'b0;
    step_q.push_back(w);
  endfunction

  function automatic void put_decoded(input logic [7:0] b);
    if (scan_ph != PH_DECODE) return;
    if (emit_n < limit_q) begin
      push_word(b, KIND_DATA, 1'b0);
      emit_n++;
    end else begin
      scan_ph = PH_DONE_FOUND;
    end
  endfunction

  function automatic void decode_plain(input logic [7:0] c);
    if (scan_ph != PH_DECODE) return;
    if (emit_n >= limit_q || c == ChAmp) begin
      scan_ph = PH_DONE_FOUND;
      return;
    end
    if (c == ChCr || c == ChLf || c == ChTab) return;
    if (c == ChPlus) put_decoded(ChSpace);
    else if (c == ChPct) held_n = 2'd1;
    else put_decoded(c);
  endfunction

  // Emit a pending escape literally
  function automatic void flush_held();
    logic [1:0] n;
    n      = held_n;
    held_n = '0;
    if (n >= 2'd1) put_decoded(ChPct);
    if (n >= 2'd2) put_decoded(held_q[7:0]);
    held_q = '0;
  endfunction

  function automatic void decode_in(input logic [7:0] c);
    logic [7:0] v;
    if (held_n == 2'd2) begin
      if (is_hex_digit(c)) begin
        v      = {nibble_of(held_q[7:0]), nibble_of(c)};
        held_n = '0;
        held_q = '0;
        put_decoded(v);
        return;
      end
      flush_held();
    end else if (held_n == 2'd1) begin
      if (is_hex_digit(c)) begin
        held_q = {8'h00, c};
        held_n = 2'd2;
        return;
      end
      flush_held();
    end
    if (c == ChNul) begin
      if (scan_ph == PH_DECODE) scan_ph = PH_DONE_FOUND;
      return;
    end
    decode_plain(c);
  endfunction

  function automatic void search_key(input logic [7:0] c, input int unsigned len);
    logic [63:0] key;
    logic [63:0] win;
    logic [63:0] mask;
    if (c == ChNul) begin
      scan_ph = PH_DONE_MISS;
      return;
    end
    window_q = {fold_case(c), window_q[63:8]};
    if (fill_n < 4'd8) fill_n++;
    if (fill_n < len) return;
    key = '0;
    for (int i = 0; i < len; i++) key[8*i +: 8] = fold_case(key_q[8*i +: 8]);
    win  = window_q >> (8 * (8 - len));
    mask = (len >= 8) ? {64{1'b1}} : ((64'd1 << (8 * len)) - 64'd1);
    if ((win & mask) == key) scan_ph = PH_SKIP;
  endfunction

  // Predict the results of one accepted input word and queue them
  function automatic void scan_query_byte(input logic [7:0] c, input logic eos);
    int unsigned len;
    logic fnd;
    len = (klen_q > 4'd8) ? 8 : klen_q;
    step_q.delete();
    if (scan_ph == PH_SEARCH && len == 0) scan_ph = PH_SKIP;
    case (scan_ph)
      PH_SEARCH: search_key(c, len);
      PH_SKIP:   scan_ph = (c != ChNul) ? PH_FIRST : PH_DONE_MISS;
      PH_FIRST: begin
        if (c == ChNul) begin
          scan_ph = PH_DONE_MISS;
        end else begin
          scan_ph = PH_DECODE;
          decode_in(c);
        end
      end
      PH_DECODE: decode_in(c);
      default: ;
    endcase
    if (eos) begin
      if (scan_ph == PH_DECODE) flush_held();
      fnd = (scan_ph == PH_DECODE || scan_ph == PH_DONE_FOUND);
      push_word(8'h00, KIND_STATUS, fnd);
      clear_scan();
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) decoded_q.push_back(step_q[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   = KeyTextReset;
      klen_q  = KeyLengthReset;
      limit_q = DefaultLimit;
      clear_scan();
      decoded_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
      found_o      = 0;
      pending_o    = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[qfpd_pkg::CfgAddrW-1:3])
          REG_KEY_TEXT:   key_q   = pwdata_i;
          REG_KEY_LENGTH: klen_q  = pwdata_i[3:0];
          REG_MAX_LENGTH: limit_q = pwdata_i[15:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid_i && s_axis_tready_i) scan_query_byte(s_axis_tdata_i, s_axis_tlast_i);

      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.out_byte = m_axis_tdata_i;
        got.kind     = m_axis_tuser_i[0];
        got.found    = m_axis_tuser_i[1];
        got.last     = m_axis_tlast_i;
        if (decoded_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected word, got byte %02h kind %b found %b last %b",
                   $time, got.out_byte, got.kind, got.found, got.last);
        end else begin
          want = decoded_q.pop_front();
          checked_o++;
          if (want.kind == KIND_STATUS && want.found) found_o++;
          if (got.out_byte != want.out_byte || got.kind != want.kind ||
              got.found != want.found || got.last != want.last) begin
            fail_count_o++;
            $display("%0t: mismatch, expected byte %02h kind %b found %b last %b,",
                     $time, want.out_byte, want.kind, want.found, want.last);
            $display("    got byte %02h kind %b found %b last %b",
                     got.out_byte, got.kind, got.found, got.last);
          end
        end
      end
      pending_o = decoded_q.size();
    end
  end

endmodule

// File: verif/query_field_percent_decoder_core_tb.sv
module query_field_percent_decoder_core_tb;

  localparam int unsigned LimitCycles  = 200000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned TailCycles   = 20;
  localparam logic [1:0]  RegSpare     = 2'd3;

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic [7:0]                    s_axis_tdata_i  = 8'h00;
  logic                          s_axis_tlast_i  = 1'b0;
  logic                          m_axis_tready_i = 1'b0;
  logic                          psel_i          = 1'b0;
  logic                          penable_i       = 1'b0;
  logic                          pwrite_i        = 1'b0;
  logic [qfpd_pkg::CfgAddrW-1:0] paddr_i         = '0;
  logic [63:0]                   pwdata_i        = '0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [7:0]  m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic [63:0] prdata_o;
  logic        pready_o;

  int fail_count;
  int pending_words;
  int words_checked;
  int strings_found;

  int unsigned items_sent   = 0;
  int unsigned settings_run = 0;
  int unsigned burst_left   = 0;
  logic        calm         = 1'b0;
  logic        rx_ready     = 1'b0;
  int unsigned rx_hold      = 0;

  logic [63:0] cur_key = qfpd_pkg::KeyTextReset;
  logic [3:0]  cur_len = qfpd_pkg::KeyLengthReset;
  logic [7:0]  query_q[$];

  always #5 clk_i = ~clk_i;

  query_field_percent_decoder_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel_i          (psel_i),
    .penable_i       (penable_i),
    .pwrite_i        (pwrite_i),
    .paddr_i         (paddr_i),
    .pwdata_i        (pwdata_i),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  query_field_percent_decoder_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .psel_i          (psel_i),
    .penable_i       (penable_i),
    .pwrite_i        (pwrite_i),
    .paddr_i         (paddr_i),
    .pwdata_i        (pwdata_i),
    .pready_i        (pready_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_words),
    .checked_o       (words_checked),
    .found_o         (strings_found)
  );

  // Receiver: alternate ready runs and stalls of random length, or stay ready while calm
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold == 0) begin
        rx_ready = ~rx_ready;
        rx_hold  = rx_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
      end
      rx_hold--;
      m_axis_tready_i = calm ? 1'b1 : rx_ready;
    end
  end

  initial begin
    repeat (LimitCycles) @(posedge clk_i);
    $display("timeout after %0d cycles", LimitCycles);
    $display("simulation failed");
    $finish;
  end

  function automatic logic [7:0] rand_letter();
    logic [7:0] l;
    l = 8'($urandom_range(0, 25));
    return ($urandom_range(0, 1) ? "A" : "a") + l;
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if (((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) && $urandom_range(0, 1))
      return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] pick_from(input string pool);
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  // Letters in the used key bytes, random bytes above them
  function automatic logic [63:0] rand_key(input int unsigned n);
    logic [63:0] k;
    for (int i = 0; i < 8; i++)
      k[8*i +: 8] = (i < n) ? rand_letter() : 8'($urandom_range(0, 255));
    return k;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) query_q.push_back(s[i]);
  endtask

  task automatic add_value_piece();
    case ($urandom_range(0, 11))
      0, 1, 2, 3: query_q.push_back(pick_from("agtTAGxyz019=._-"));
      4:          query_q.push_back(qfpd_pkg::ChPlus);
      5:          query_q.push_back(pick_from("\r\n\t"));
      6, 7: begin
        query_q.push_back(qfpd_pkg::ChPct);
        query_q.push_back(pick_from("0123456789abcdefABCDEF"));
        query_q.push_back(pick_from("0123456789abcdefABCDEF"));
      end
      8: begin
        query_q.push_back(qfpd_pkg::ChPct);
        query_q.push_back(pick_from("0123456789abcdefABCDEF"));
        query_q.push_back(pick_from("gGzZ+&=% x"));
      end
      9: begin
        query_q.push_back(qfpd_pkg::ChPct);
        query_q.push_back(pick_from("gGzZ+&=% x"));
      end
      10:      query_q.push_back(qfpd_pkg::ChAmp);
      default: query_q.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  // Mostly prefix, key, separator and value; sometimes noise or a cut-off key
  task automatic make_query();
    int unsigned klen;
    int unsigned keep;
    int unsigned style;
    query_q.delete();
    klen  = (cur_len > 4'd8) ? 8 : cur_len;
    style = $urandom_range(0, 9);
    if (style == 0) begin
      repeat ($urandom_range(1, 10)) query_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) query_q.push_back(pick_from("agtTAGxyz019=._-&"));
      keep = (style == 1) ? $urandom_range(0, klen) : klen;
      for (int i = 0; i < keep; i++) query_q.push_back(flip_case(cur_key[8*i +: 8]));
      if (style > 1 || (keep == klen && $urandom_range(0, 1))) begin
        query_q.push_back($urandom_range(0, 3) ? "=" : 8'($urandom_range(0, 255)));
        if (style > 1) repeat ($urandom_range(0, 5)) add_value_piece();
      end
    end
    if (query_q.size() == 0) query_q.push_back(pick_from("agtTAGxyz019=._-"));
  endtask

  task automatic send_word(input logic [7:0] b, input logic l);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = b;
    s_axis_tlast_i  = l;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_query();
    calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < query_q.size(); i++) send_word(query_q[i], i == query_q.size() - 1);
  endtask

  // Wait until every expected word has come out and the block has gone quiet
  task automatic settle(input int unsigned extra);
    s_axis_tvalid_i = 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    psel_i    = 1'b1;
    penable_i = 1'b0;
    pwrite_i  = 1'b1;
    paddr_i   = {idx, 3'b000};
    pwdata_i  = val;
    @(negedge clk_i);
    penable_i = 1'b1;
    do @(posedge clk_i); while (!pready_o);
    @(negedge clk_i);
    psel_i    = 1'b0;
    penable_i = 1'b0;
    pwrite_i  = 1'b0;
  endtask

  task automatic run_setting(input logic [63:0] key, input logic [3:0] len,
                             input logic [15:0] lim, input int unsigned n);
    int unsigned goal;
    settle(SettleCycles);
    write_reg(qfpd_pkg::REG_KEY_TEXT, key);
    write_reg(qfpd_pkg::REG_KEY_LENGTH, {60'd0, len});
    write_reg(qfpd_pkg::REG_MAX_LENGTH, {48'd0, lim});
    cur_key = key;
    cur_len = len;
    settings_run++;
    goal = items_sent + n;
    while (items_sent < goal) begin
      make_query();
      send_query();
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    settings_run = 1;

    // Reset key: escapes, a four-word burst, match at the end, separator only,
    // a zero byte in the search and a pending escape at the end
    query_q.delete();
    add_text("xTaG=%4a\t%C+");
    send_query();
    query_q.delete();
    add_text("tag");
    send_query();
    query_q.delete();
    add_text("tag=");
    send_query();
    query_q.delete();
    add_text("t");
    query_q.push_back(qfpd_pkg::ChNul);
    add_text("g");
    send_query();
    query_q.delete();
    add_text("tag=%");
    send_query();

    run_setting(qfpd_pkg::KeyTextReset, qfpd_pkg::KeyLengthReset, qfpd_pkg::DefaultLimit, 15);
    run_setting(rand_key(4), 4'd4, 16'd1024, 15);
    run_setting(rand_key(3), 4'd0, 16'd3, 15);
    run_setting(rand_key(8), 4'd15, 16'hffff, 15);
    run_setting(qfpd_pkg::KeyTextReset, 4'd3, 16'd0, 15);
    run_setting({64{1'b1}}, 4'd8, 16'd2, 15);
    settle(SettleCycles);
    write_reg(RegSpare, {$urandom, $urandom});
    run_setting(64'd0, 4'd1, 16'd1, 12);
    run_setting(rand_key(2), 4'd2, 16'd1024, 15);
    run_setting(rand_key(8), 4'($urandom_range(1, 8)), 16'($urandom_range(1, 20)), 15);

    settle(TailCycles);
    $display("sent %0d query bytes over %0d key/limit settings", items_sent, settings_run);
    $display("checked %0d result words, %0d strings reported a value", words_checked,
             strings_found);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d failures", fail_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: query_field_percent_decoder_core.f
src/qfpd_pkg.sv
src/qfpd_scan.sv
src/qfpd_obuf.sv
src/query_field_percent_decoder_core.sv
verif/query_field_percent_decoder_checker.sv
verif/query_field_percent_decoder_core_tb.sv
